// ===== rtl/latency_histogram_percentile_unit_defines.svh =====
// Assertion macros for the latency histogram percentile unit.
// Used by the top level only; no other dependencies.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_UNIT_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LHP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lhp_pkg.sv =====
// Shared constants, types and the bin bound table of the latency histogram unit.
// No dependencies; used by every module of the block.
`default_nettype none

package lhp_pkg;

    localparam int NUM_BINS    = 32;
    localparam int SAMPLE_BITS = 48;
    localparam int COUNT_BITS  = 32;

    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int SUM_BITS   = 64;
    localparam int CUM_BITS   = 64;
    localparam int FRAC_BITS  = 17;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_BITS  = COUNT_BITS + FRAC_BITS;

    // Field widths on the stream ports
    localparam int CMD_W   = 2;
    localparam int NS_W    = 48;
    localparam int BIN_W   = 5;
    localparam int TOTAL_W = 32;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 248;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [CUM_BITS-1:0]    cum_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [BIN_BITS-1:0]    bin_idx_t;
    typedef logic [CMD_W-1:0]       cmd_t;

    localparam cmd_t CMD_RECORD = 2'd0;
    localparam cmd_t CMD_QUERY  = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

    localparam sample_t SAMPLE_MAX = '1;
    localparam count_t  COUNT_MAX  = '1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_REC   = 5'b00010,
        ST_QTGT  = 5'b00100,
        ST_QWALK = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    // One access to the bin store per cycle, plus a bulk clear
    typedef struct packed {
        logic     rd_en;
        bin_idx_t rd_addr;
        logic     wr_en;
        bin_idx_t wr_addr;
        count_t   wr_data;
        logic     clear;
    } store_req_t;

    typedef sample_t bound_tbl_t [NUM_BINS];

    // Bound i is floor(1000 * 1.5^i), kept exact with a 64-bit integer part
    // and a 64-bit binary fraction; each step triples and halves.
    function automatic bound_tbl_t build_bounds();
        bound_tbl_t        tbl;
        logic [63:0]       q;
        logic [63:0]       f;
        logic [65:0]       f3;
        logic [63:0]       q3;
        logic [63:0]       smask;
        smask = {64{1'b1}} >> (64 - SAMPLE_BITS);
        q = 64'd1000;
        f = 64'd0;
        for (int i = 0; i < NUM_BINS; i++) begin
            tbl[i] = (q > smask) ? SAMPLE_MAX : sample_t'(q);
            f3 = {2'b00, f} + {1'b0, f, 1'b0};
            q3 = q * 64'd3 + 64'(f3[65:64]);
            f  = {q3[0], f3[63:1]};
            q  = q3 >> 1;
        end
        return tbl;
    endfunction

    localparam bound_tbl_t BIN_BOUND = build_bounds();

    // Saturate a port sample into the internal sample width
    function automatic sample_t clamp_sample(logic [NS_W-1:0] ns);
        logic [NS_W-1:0] hi;
        hi = ns >> SAMPLE_BITS;
        return (hi != '0) ? SAMPLE_MAX : sample_t'(ns);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lhp_bin_store.sv =====
// Bin count memory: one read and one write port, registered read data.
// Per-entry valid flags give the cleared value without a sweep. Uses lhp_pkg.
`default_nettype none

module lhp_bin_store (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lhp_pkg::store_req_t req,
    output lhp_pkg::count_t          rd_data
);

    lhp_pkg::count_t                  bin_mem [lhp_pkg::NUM_BINS];
    lhp_pkg::count_t                  rd_raw_reg;
    logic                             rd_valid_reg;
    logic [lhp_pkg::NUM_BINS-1:0]     valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            bin_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_raw_reg <= bin_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.clear) begin
                valid_reg <= '0;
            end else if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since clear reads as zero
    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/lhp_bin_find.sv =====
// Bin lookup: first bin whose bound is at least the sample, else the last bin.
// Compares against the constant bound table in lhp_pkg.
`default_nettype none

module lhp_bin_find (
    input  wire lhp_pkg::sample_t ns,
    output lhp_pkg::bin_idx_t     bin
);

    always_comb begin
        bin = lhp_pkg::bin_idx_t'(lhp_pkg::NUM_BINS - 1);
        for (int i = lhp_pkg::NUM_BINS - 1; i >= 0; i--) begin
            if (lhp_pkg::BIN_BOUND[i] >= ns) begin
                bin = lhp_pkg::bin_idx_t'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/latency_histogram_percentile_unit.sv =====
// Latency histogram monitor: record, percentile query and clear commands.
// Record looks up the bin and reads its count, then writes the count back; clear, the unused
// command and a query on an empty histogram finish on acceptance; any other query forms its
// target, then walks 1..32 bins, one bin per cycle through the single read port of the store.
// One transaction is in flight at a time; the result register frees the input side. A result
// the receiver holds off stalls the input once the next finishes, as long as the register is full.
// Reset (aresetn, synchronous, active low) empties bins and statistics at once.
`default_nettype none

module latency_histogram_percentile_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Command channel
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [lhp_pkg::IN_W-1:0]     s_tdata,  // sample_ns[47:0], pct_fraction[64:48]
    input  wire logic [lhp_pkg::CMD_W-1:0]    s_tuser,  // cmd[1:0]
    // Result channel
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [lhp_pkg::OUT_W-1:0]    m_tdata   // bin_index[4:0], pct_latency_ns[52:5],
                                                        // sample_total[84:53],
                                                        // min_latency_ns[132:85],
                                                        // max_latency_ns[180:133],
                                                        // sum_of_samples_ns[244:181]
);

`include "latency_histogram_percentile_unit_defines.svh"

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    lhp_pkg::state_t                  state_reg, state_next;
    lhp_pkg::sample_t                 ns_reg, ns_next;
    lhp_pkg::bin_idx_t                bin_reg, bin_next;
    logic [lhp_pkg::PROD_BITS-1:0]    prod_reg, prod_next;
    lhp_pkg::cum_t                    target_reg, target_next;
    lhp_pkg::cum_t                    cum_reg, cum_next;
    lhp_pkg::bin_idx_t                walk_reg, walk_next;
    lhp_pkg::bin_idx_t                pend_bin_reg, pend_bin_next;
    lhp_pkg::sample_t                 pend_pct_reg, pend_pct_next;

    lhp_pkg::count_t                  count_reg, count_next;
    lhp_pkg::sum_t                    sum_reg, sum_next;
    lhp_pkg::sample_t                 min_reg, min_next;
    lhp_pkg::sample_t                 max_reg, max_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [lhp_pkg::OUT_W-1:0]        m_tdata_reg, m_tdata_next;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic                             in_acc;
    lhp_pkg::cmd_t                    in_cmd;
    lhp_pkg::sample_t                 in_ns;
    logic [lhp_pkg::FRAC_BITS-1:0]    in_pct;
    lhp_pkg::bin_idx_t                in_bin;
    logic                             out_free;

    assign s_tready = (state_reg == lhp_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_cmd   = s_tuser;
    assign in_ns    = lhp_pkg::clamp_sample(s_tdata[lhp_pkg::NS_W-1:0]);
    assign in_pct   = s_tdata[lhp_pkg::NS_W +: lhp_pkg::FRAC_BITS];
    assign out_free = !m_tvalid_reg || m_tready;

    lhp_bin_find u_find (
        .ns  (in_ns),
        .bin (in_bin)
    );

    // ---------------------------------------------------------------
    // Bin store
    // ---------------------------------------------------------------
    lhp_pkg::store_req_t              store_req;
    lhp_pkg::count_t                  rd_data;

    lhp_bin_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [lhp_pkg::CUM_BITS:0]       tgt_wide;
    lhp_pkg::cum_t                    tgt_sat;
    logic [lhp_pkg::CUM_BITS:0]       cum_wide;
    lhp_pkg::cum_t                    cum_sat;
    logic                             walk_hit;
    logic                             walk_last;
    logic [lhp_pkg::SUM_BITS:0]       sum_wide;
    lhp_pkg::count_t                  bin_inc;

    // target = floor(count * p / 2^16), saturated to 64 bits, at least 1
    assign tgt_wide  = (lhp_pkg::CUM_BITS + 1)'(
                           prod_reg[lhp_pkg::PROD_BITS-1:lhp_pkg::FRAC_SHIFT]);
    assign tgt_sat   = tgt_wide[lhp_pkg::CUM_BITS] ? '1 : tgt_wide[lhp_pkg::CUM_BITS-1:0];

    assign cum_wide  = {1'b0, cum_reg} + (lhp_pkg::CUM_BITS + 1)'(rd_data);
    assign cum_sat   = cum_wide[lhp_pkg::CUM_BITS] ? '1 : cum_wide[lhp_pkg::CUM_BITS-1:0];
    assign walk_hit  = (cum_sat >= target_reg);
    assign walk_last = (walk_reg == lhp_pkg::bin_idx_t'(lhp_pkg::NUM_BINS - 1));

    assign sum_wide  = {1'b0, sum_reg} + (lhp_pkg::SUM_BITS + 1)'(ns_reg);
    assign bin_inc   = (rd_data == lhp_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;

    // ---------------------------------------------------------------
    // Control and statistics
    // ---------------------------------------------------------------
    logic                             fin;
    lhp_pkg::bin_idx_t                fin_bin;
    lhp_pkg::sample_t                 fin_pct;
    logic                             load_out;

    always_comb begin
        state_next    = state_reg;
        ns_next       = ns_reg;
        bin_next      = bin_reg;
        prod_next     = prod_reg;
        target_next   = target_reg;
        cum_next      = cum_reg;
        walk_next     = walk_reg;
        pend_bin_next = pend_bin_reg;
        pend_pct_next = pend_pct_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        min_next      = min_reg;
        max_next      = max_reg;

        store_req     = '0;
        fin           = 1'b0;
        fin_bin       = '0;
        fin_pct       = '0;
        load_out      = 1'b0;

        case (state_reg)
            lhp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        lhp_pkg::CMD_RECORD: begin
                            // Look up the bin and start the count read
                            ns_next           = in_ns;
                            bin_next          = in_bin;
                            store_req.rd_en   = 1'b1;
                            store_req.rd_addr = in_bin;
                            state_next        = lhp_pkg::ST_REC;
                        end
                        lhp_pkg::CMD_QUERY: begin
                            if (count_reg == '0) begin
                                fin = 1'b1;
                            end else begin
                                prod_next  = lhp_pkg::PROD_BITS'(count_reg) *
                                             lhp_pkg::PROD_BITS'(in_pct);
                                state_next = lhp_pkg::ST_QTGT;
                            end
                        end
                        lhp_pkg::CMD_CLEAR: begin
                            store_req.clear = 1'b1;
                            count_next      = '0;
                            sum_next        = '0;
                            min_next        = lhp_pkg::SAMPLE_MAX;
                            max_next        = '0;
                            fin             = 1'b1;
                        end
                        default: begin
                            // Unused command: report statistics only
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            lhp_pkg::ST_REC: begin
                // Write back the bumped count and fold the sample into the stats
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = bin_reg;
                store_req.wr_data = bin_inc;
                if (count_reg != lhp_pkg::COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
                sum_next = sum_wide[lhp_pkg::SUM_BITS] ? '1 : sum_wide[lhp_pkg::SUM_BITS-1:0];
                if (ns_reg < min_reg) begin
                    min_next = ns_reg;
                end
                if (ns_reg > max_reg) begin
                    max_next = ns_reg;
                end
                fin     = 1'b1;
                fin_bin = bin_reg;
            end

            lhp_pkg::ST_QTGT: begin
                target_next       = (tgt_sat == '0) ? lhp_pkg::cum_t'(1) : tgt_sat;
                cum_next          = '0;
                walk_next         = '0;
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = '0;
                state_next        = lhp_pkg::ST_QWALK;
            end

            lhp_pkg::ST_QWALK: begin
                // Accumulate one bin per cycle; stop at the first bin reaching target, or at the last bin
                if (walk_hit) begin
                    fin     = 1'b1;
                    fin_pct = lhp_pkg::BIN_BOUND[walk_reg];
                end else if (walk_last) begin
                    fin     = 1'b1;
                    fin_pct = max_reg;
                end else begin
                    cum_next          = cum_sat;
                    walk_next         = walk_reg + 1'b1;
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = walk_reg + 1'b1;
                end
            end

            lhp_pkg::ST_RESP: begin
                // Hold the finished result until the output register frees up
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = lhp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lhp_pkg::ST_IDLE;
            end
        endcase

        if (fin) begin
            pend_bin_next = fin_bin;
            pend_pct_next = fin_pct;
            if (out_free) begin
                load_out   = 1'b1;
                state_next = lhp_pkg::ST_IDLE;
            end else begin
                state_next = lhp_pkg::ST_RESP;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    lhp_pkg::bin_idx_t                res_bin;
    lhp_pkg::sample_t                 res_pct;
    lhp_pkg::sample_t                 res_min;

    assign res_bin = (state_reg == lhp_pkg::ST_RESP) ? pend_bin_reg : fin_bin;
    assign res_pct = (state_reg == lhp_pkg::ST_RESP) ? pend_pct_reg : fin_pct;
    assign res_min = (count_next != '0) ? min_next : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000,
                             lhp_pkg::SUM_BITS'(sum_next),
                             lhp_pkg::NS_W'(max_next),
                             lhp_pkg::NS_W'(res_min),
                             lhp_pkg::TOTAL_W'(count_next),
                             lhp_pkg::NS_W'(res_pct),
                             lhp_pkg::BIN_W'(res_bin)};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Sequential
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lhp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            min_reg      <= lhp_pkg::SAMPLE_MAX;
            max_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        ns_reg       <= ns_next;
        bin_reg      <= bin_next;
        prod_reg     <= prod_next;
        target_reg   <= target_next;
        cum_reg      <= cum_next;
        walk_reg     <= walk_next;
        pend_bin_reg <= pend_bin_next;
        pend_pct_reg <= pend_pct_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic [lhp_pkg::TOTAL_W-1:0]      chk_total;
    logic [lhp_pkg::NS_W-1:0]         chk_min;
    logic [lhp_pkg::NS_W-1:0]         chk_max;

    assign chk_total = m_tdata[84:53];
    assign chk_min   = m_tdata[132:85];
    assign chk_max   = m_tdata[180:133];

    // A record holds the input off for its write-back cycle
    `LHP_ASSERT_NXT(a_rec_busy, aclk, aresetn,
                    in_acc && (in_cmd == lhp_pkg::CMD_RECORD),
                    !s_tready, "accept during record write-back")

    // The sample count only falls on a clear
    `LHP_ASSERT_NXT(a_count_monotonic, aclk, aresetn,
                    !(in_acc && (in_cmd == lhp_pkg::CMD_CLEAR)),
                    count_reg >= $past(count_reg), "sample count dropped without clear")

    // A reported non-empty histogram has its minimum at or below its maximum
    `LHP_ASSERT_IMP(a_min_le_max, aclk, aresetn, m_tvalid && (chk_total != '0),
                    chk_min <= chk_max, "reported min above max")

endmodule

`default_nettype wire

// ===== verif/tb_latency_histogram_percentile_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for latency_histogram_percentile_unit: record, query, clear and
// unused commands against a scoreboard that keeps its own histogram and statistics.
// Depends on lhp_pkg and the top-level RTL only.

module tb_latency_histogram_percentile_unit;

    import lhp_pkg::*;

    // The command field has one encoding the block does not use; it must pass statistics only.
    localparam cmd_t CMD_UNUSED     = 2'd3;
    localparam int   MAX_GAP        = 17;
    localparam int   HOLD_CYCLES    = 300;
    // Margin at the end of the run, sized generously above the longest query, which walks all bins.
    localparam int   DRAIN_CYCLES   = 64;
    localparam int   PHASE_ITEMS    = 110;
    localparam int   TIMEOUT_CYCLES = 400000;
    localparam logic [16:0] FRAC_ONE = 17'd65536;

    // One result transaction, unpacked from m_tdata.
    typedef struct {
        bin_idx_t bin;
        sample_t  pct;
        count_t   total;
        sample_t  min_ns;
        sample_t  max_ns;
        sum_t     sum_ns;
    } hist_result_t;

    // Scoreboard: mirrors the bin store and statistics, queues the expected results.
    class hist_scoreboard;
        sample_t      bin_bound [NUM_BINS];
        count_t       bin_count [NUM_BINS];
        count_t       n_samples;
        sum_t         sum_ns;
        sample_t      min_ns;
        sample_t      max_ns;
        hist_result_t due_results [$];
        int           failures;

        function new();
            logic [129:0] scaled;
            // Keep 1000 * 1.5^i exactly as a 66.64 fixed-point value; the integer
            // part is the bound. Tripling then halving never drops a set bit here.
            scaled = 130'd1000 << 64;
            for (int i = 0; i < NUM_BINS; i++) begin
                if (scaled[129:64] > 66'(SAMPLE_MAX))
                    bin_bound[i] = SAMPLE_MAX;
                else
                    bin_bound[i] = scaled[111:64];
                scaled = (scaled * 3) >> 1;
            end
            clear_stats();
            failures = 0;
        endfunction

        function void clear_stats();
            foreach (bin_count[i]) bin_count[i] = '0;
            n_samples = '0;
            sum_ns    = '0;
            min_ns    = SAMPLE_MAX;
            max_ns    = '0;
        endfunction

        // Apply one accepted command to the mirror state and queue its result.
        function void note_command(cmd_t cmd, sample_t ns, logic [16:0] frac);
            hist_result_t r;
            logic [48:0]  prod;
            logic [63:0]  target;
            logic [63:0]  cum;
            logic [64:0]  wide_sum;
            logic         hit;
            r.bin = '0;
            r.pct = '0;
            case (cmd)
                CMD_RECORD: begin
                    // Scan downward so the lowest bin whose bound covers the sample wins
                    r.bin = bin_idx_t'(NUM_BINS - 1);
                    for (int i = NUM_BINS - 1; i >= 0; i--)
                        if (bin_bound[i] >= ns) r.bin = bin_idx_t'(i);
                    if (bin_count[r.bin] != COUNT_MAX) bin_count[r.bin] += 1'b1;
                    if (n_samples != COUNT_MAX) n_samples += 1'b1;
                    wide_sum = {1'b0, sum_ns} + 65'(ns);
                    sum_ns   = wide_sum[64] ? '1 : wide_sum[63:0];
                    if (ns < min_ns) min_ns = ns;
                    if (ns > max_ns) max_ns = ns;
                end
                CMD_QUERY: begin
                    if (n_samples != '0) begin
                        prod   = 49'(n_samples) * 49'(frac);
                        target = 64'(prod[48:16]);
                        if (target == '0) target = 64'd1;
                        // No bin reaching the target means the answer is the maximum
                        cum   = '0;
                        hit   = 1'b0;
                        r.pct = max_ns;
                        for (int i = 0; i < NUM_BINS; i++) begin
                            cum = cum + 64'(bin_count[i]);
                            if (!hit && cum >= target) begin
                                hit   = 1'b1;
                                r.pct = bin_bound[i];
                            end
                        end
                    end
                end
                CMD_CLEAR: clear_stats();
                default: ;
            endcase
            r.total  = n_samples;
            r.min_ns = (n_samples != '0) ? min_ns : '0;
            r.max_ns = max_ns;
            r.sum_ns = sum_ns;
            due_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest queued expectation.
        function void check_result(logic [OUT_W-1:0] tdata);
            hist_result_t got;
            hist_result_t want;
            got.bin    = tdata[4:0];
            got.pct    = tdata[52:5];
            got.total  = tdata[84:53];
            got.min_ns = tdata[132:85];
            got.max_ns = tdata[180:133];
            got.sum_ns = tdata[244:181];
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("bad result %0d: unexpected transaction, bin=%0d pct=%0d total=%0d",
                             failures, got.bin, got.pct, got.total);
                return;
            end
            want = due_results.pop_front();
            if (got.bin !== want.bin || got.pct !== want.pct || got.total !== want.total ||
                got.min_ns !== want.min_ns || got.max_ns !== want.max_ns ||
                got.sum_ns !== want.sum_ns) begin
                failures++;
                if (failures <= 10) begin
                    $display(
                        "bad result %0d: expected bin=%0d pct=%0d total=%0d min=%0d max=%0d sum=%0d",
                        failures, want.bin, want.pct, want.total, want.min_ns,
                        want.max_ns, want.sum_ns);
                    $display("    actual   bin=%0d pct=%0d total=%0d min=%0d max=%0d sum=%0d",
                             got.bin, got.pct, got.total, got.min_ns, got.max_ns, got.sum_ns);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    cmd_t              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    // Idling policy, switched per phase by the stimulus process
    bit                send_gaps;
    bit                recv_stalls;
    bit                hold_req;
    int unsigned       cycles = 0;

    hist_scoreboard sb = new();

    latency_histogram_percentile_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one command transaction, optionally after a random gap, and hold it until
    // accepted. Valid stays high across back-to-back transactions.
    task automatic send_cmd(cmd_t cmd, sample_t ns, logic [16:0] frac);
        int gap;
        gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, frac, ns};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_command(cmd, ns, frac);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Stimulus: reset, directed corner cases, then random phases with varied idling.
    initial begin
        int unsigned r;
        int          k;
        sample_t     ns;
        logic [16:0] frac;
        cmd_t        cmd;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_RECORD;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        hold_req    = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty histogram: query answers zero, unused command changes nothing
        send_cmd(CMD_QUERY, '0, FRAC_ONE);
        send_cmd(CMD_UNUSED, '0, '0);
        // Bin edges: zero, exactly on a bound, one past it, the top bound and beyond
        send_cmd(CMD_RECORD, '0, '0);
        send_cmd(CMD_RECORD, sb.bin_bound[0], '0);
        send_cmd(CMD_RECORD, sb.bin_bound[0] + 1'b1, '0);
        send_cmd(CMD_RECORD, sb.bin_bound[15], '0);
        send_cmd(CMD_RECORD, sb.bin_bound[NUM_BINS-1], '0);
        send_cmd(CMD_RECORD, sb.bin_bound[NUM_BINS-1] + 1'b1, '0);
        send_cmd(CMD_RECORD, SAMPLE_MAX, '0);
        // Percentiles: zero fraction raised to a target of one, middle, full, and above
        // one so that no bin reaches the target and the maximum comes back
        send_cmd(CMD_QUERY, SAMPLE_MAX, 17'd0);
        send_cmd(CMD_QUERY, '0, 17'd32768);
        send_cmd(CMD_QUERY, '0, 17'd65535);
        send_cmd(CMD_QUERY, '0, FRAC_ONE);
        send_cmd(CMD_QUERY, '0, 17'h1FFFF);
        send_cmd(CMD_UNUSED, SAMPLE_MAX, 17'h1FFFF);
        // Clear, then confirm the store is empty and refills correctly
        send_cmd(CMD_CLEAR, SAMPLE_MAX, 17'h1FFFF);
        send_cmd(CMD_QUERY, '0, 17'd40000);
        send_cmd(CMD_RECORD, 48'h8000_0000_0000, '0);
        send_cmd(CMD_RECORD, 48'd1, '0);
        send_cmd(CMD_QUERY, '0, 17'd1);
        send_cmd(CMD_QUERY, '0, FRAC_ONE);
        send_cmd(CMD_CLEAR, '0, '0);
        drain_results();

        // Phase 0: both sides idle at random; 1: no idling at all; 2: random idling plus
        // a long receiver hold-off; 3: sender gaps only; 4: receiver stalls only.
        for (int phase = 0; phase < 5; phase++) begin
            send_gaps   = (phase != 1) && (phase != 4);
            recv_stalls = (phase != 1) && (phase != 3);
            if (phase == 2) hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                r    = $urandom_range(0, 99);
                // Fields a command ignores still carry random content
                ns   = sample_t'({$urandom, $urandom});
                frac = 17'($urandom);
                if (r < 70) begin
                    cmd = CMD_RECORD;
                    k   = $urandom_range(0, NUM_BINS - 1);
                    case ($urandom_range(0, 9))
                        0, 1: ;   // wide sample, mostly lands in the last bin
                        2:       ns = sample_t'($urandom_range(0, 1500));
                        default: ns = sample_t'($urandom_range(0, 32'(sb.bin_bound[k])));
                    endcase
                end else if (r < 88) begin
                    cmd = CMD_QUERY;
                    if ($urandom_range(0, 4) != 0)
                        frac = 17'($urandom_range(0, 65536));
                end else if (r < 91) begin
                    cmd = CMD_CLEAR;
                end else if (r < 94) begin
                    cmd = CMD_UNUSED;
                end else begin
                    // Exactly on a bound or just past it
                    cmd = CMD_RECORD;
                    k   = $urandom_range(0, NUM_BINS - 1);
                    ns  = sb.bin_bound[k] + sample_t'($urandom_range(0, 1));
                end
                send_cmd(cmd, ns, frac);
            end
            // Pause the sender until every result of the phase is back
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random stalls per transaction, plus one long hold-off on request.
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (hold_req) begin
                // Hold ready low long enough for the block to back up into its input
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = recv_stalls ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
        end
    end

    // Advance the cycle counter and end the run if it hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
